### design/i2crw_pkg.sv
// Package for the I2C register write master.
// Holds the frame constants, the result struct and the frame builder function.
// No dependencies.
package i2crw_pkg;

   localparam int FrameBits = 9 * 3;
   localparam int PosWidth = $clog2(FrameBits);
   localparam int TickWidth = 16;
   localparam logic [TickWidth-1:0] PhaseTicksReset = 16'd20;
   localparam logic [PosWidth-1:0] LastBitPos = PosWidth'(FrameBits - 1);

   typedef logic [FrameBits-1:0] frame_type;

   // Levels and flags produced for one transaction.
   typedef struct packed {
      logic scl;
      logic sda;
      logic busy;
      logic done;
      logic rejected;
   } i2crw_result_type;

   // Address, write bit 0, released ACK slot, register byte, ACK slot,
   // data byte, ACK slot; sent MSB first.
   function automatic frame_type build_frame(input logic [6:0] addr,
                                             input logic [7:0] regi,
                                             input logic [7:0] data);
      build_frame = {addr, 1'b0, 1'b1, regi, 1'b1, data, 1'b1};
   endfunction

endpackage

### design/i2crw_engine.sv
// Bit sequencer of the I2C register write master.
// Holds the frame state and computes the pin levels for one transaction.
// Depends on i2crw_pkg.
module i2crw_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic                           mode,
   input  logic [6:0]                     device_address,
   input  logic [7:0]                     register_index,
   input  logic [7:0]                     write_value,
   input  logic [i2crw_pkg::TickWidth-1:0] phase_ticks,
   output i2crw_pkg::i2crw_result_type    result
);
   import i2crw_pkg::*;

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_START,
      STEP_BITS,
      STEP_STOP
   } step_type;

   step_type               step_ff, step_in;
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic [1:0]             phase_ff, phase_in;
   logic [TickWidth-1:0]   hold_ff, hold_in;
   frame_type              frame_ff, frame_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;

   logic                   busy;
   logic                   done;
   logic                   rej;
   logic [TickWidth-1:0]   hold_inc;
   logic [TickWidth-1:0]   limit;

   assign busy = (step_ff != STEP_IDLE);
   assign hold_inc = hold_ff + TickWidth'(1);
   assign limit = (phase_ticks == '0) ? TickWidth'(1) : phase_ticks;

   always_comb begin
      step_in = step_ff;
      pos_in = pos_ff;
      phase_in = phase_ff;
      hold_in = hold_ff;
      frame_in = frame_ff;
      scl_in = scl_ff;
      sda_in = sda_ff;
      done = 1'b0;
      rej = 1'b0;
      if (mode) begin
         if (busy) begin
            rej = 1'b1;
         end else begin
            frame_in = build_frame(device_address, register_index, write_value);
            step_in = STEP_START;
            pos_in = '0;
            phase_in = '0;
            hold_in = '0;
            scl_in = 1'b1;
            sda_in = 1'b0;
         end
      end else if (busy) begin
         if (hold_inc >= limit) begin
            hold_in = '0;
            case (step_ff)
               STEP_START: begin
                  if (phase_ff == 2'd0) begin
                     phase_in = 2'd1;
                     scl_in = 1'b0;
                     sda_in = 1'b0;
                  end else begin
                     step_in = STEP_BITS;
                     pos_in = '0;
                     phase_in = 2'd0;
                     sda_in = frame_ff[FrameBits-1];
                     frame_in = {frame_ff[FrameBits-2:0], 1'b0};
                     scl_in = 1'b0;
                  end
               end
               STEP_BITS: begin
                  if (phase_ff < 2'd2) begin
                     phase_in = phase_ff + 2'd1;
                     scl_in = (phase_ff == 2'd0);
                  end else if (pos_ff >= LastBitPos) begin
                     step_in = STEP_STOP;
                     phase_in = 2'd0;
                     scl_in = 1'b1;
                     sda_in = 1'b0;
                  end else begin
                     pos_in = pos_ff + PosWidth'(1);
                     phase_in = 2'd0;
                     sda_in = frame_ff[FrameBits-1];
                     frame_in = {frame_ff[FrameBits-2:0], 1'b0};
                     scl_in = 1'b0;
                  end
               end
               STEP_STOP: begin
                  if (phase_ff == 2'd0) begin
                     phase_in = 2'd1;
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                  end else begin
                     step_in = STEP_IDLE;
                     phase_in = 2'd0;
                     pos_in = '0;
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                     done = 1'b1;
                  end
               end
               default: begin
                  step_in = STEP_IDLE;
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end
            endcase
         end else begin
            hold_in = hold_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         pos_ff <= '0;
         phase_ff <= '0;
         hold_ff <= '0;
         frame_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
      end else if (fire) begin
         step_ff <= step_in;
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         hold_ff <= hold_in;
         frame_ff <= frame_in;
         scl_ff <= scl_in;
         sda_ff <= sda_in;
      end
   end

   assign result.scl = scl_in;
   assign result.sda = sda_in;
   assign result.busy = (step_in != STEP_IDLE);
   assign result.done = done;
   assign result.rejected = rej;

endmodule

### design/i2c_register_write_master.sv
// Top level of the I2C register write master.
// Input register, bit sequencer and result register; depends on i2crw_pkg
// and i2crw_engine.
//
// Usage: every request transaction on the req_ channel is either a time tick
// (req_mode 0) or a register write request (req_mode 1 with address, register
// byte and data byte). Each request yields exactly one response transaction on
// the rsp_ channel carrying the SCL and SDA levels after that request, the busy
// and done flags and a rejected flag for a write request that arrived while a
// frame was still in progress. Every pin level is held for phase_ticks ticks.
// The csr_ channel writes phase_ticks (reset value 20, zero acts as one); it is
// always ready; the user must write it only while idle, unchecked by the block.
//
// An accepted request sits in the input register, and the sequencer result is
// then captured in the response register, which raises rsp_valid. Throughput
// is one transaction per cycle while the receiver does not stall rsp_stall;
// the sequencer state is a single short update step, so a new request is
// accepted while the previous response waits. When the receiver asserts
// rsp_stall the response holds and req_stall rises only once the input
// register is also occupied.
// Synchronous reset empties both registers, returns the sequencer to idle with
// both lines released high and restores phase_ticks to 20.
module i2c_register_write_master (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [6:0]                      req_device_address,
   input  logic [7:0]                      req_register_index,
   input  logic [7:0]                      req_write_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_scl_out,
   output logic                            rsp_sda_out,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic                            rsp_rejected,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [i2crw_pkg::TickWidth-1:0] csr_phase_ticks
);
   import i2crw_pkg::*;

   logic                  in_valid_ff;
   logic                  mode_ff;
   logic [6:0]            addr_ff;
   logic [7:0]            regi_ff;
   logic [7:0]            data_ff;
   logic [TickWidth-1:0]  phase_ticks_ff;
   logic                  out_valid_ff;
   i2crw_result_type      result_ff;
   i2crw_result_type      result_in;
   logic                  advance;
   logic                  fire;

   // The result register can take a new transaction when empty or draining.
   assign advance = !out_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PhaseTicksReset;
      end else if (csr_valid) begin
         phase_ticks_ff <= csr_phase_ticks;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         mode_ff <= req_mode;
         addr_ff <= req_device_address;
         regi_ff <= req_register_index;
         data_ff <= req_write_value;
      end
   end

   i2crw_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .mode           (mode_ff),
      .device_address (addr_ff),
      .register_index (regi_ff),
      .write_value    (data_ff),
      .phase_ticks    (phase_ticks_ff),
      .result         (result_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_scl_out = result_ff.scl;
   assign rsp_sda_out = result_ff.sda;
   assign rsp_busy_res = result_ff.busy;
   assign rsp_done_res = result_ff.done;
   assign rsp_rejected = result_ff.rejected;

endmodule

### design/i2crw_checker.sv
// Port-level checker for the I2C register write master.
// Watches the top-level ports only; bound to i2c_register_write_master below.
module i2crw_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_scl_out,
   input logic rsp_sda_out,
   input logic rsp_busy_res,
   input logic rsp_done_res,
   input logic rsp_rejected
);

   // A finished frame leaves the bus released and the block idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && rsp_scl_out && rsp_sda_out)
      else $error("done without idle released bus");

   // A rejected request arrives only while a frame is running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && !rsp_done_res)
      else $error("rejected while idle");

   // When idle both lines are released high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl_out && rsp_sda_out)
      else $error("lines driven while idle");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scl_out)
         && $stable(rsp_sda_out) && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_rejected))
      else $error("stalled response changed");

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind i2c_register_write_master i2crw_checker u_i2crw_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_scl_out  (rsp_scl_out),
   .rsp_sda_out  (rsp_sda_out),
   .rsp_busy_res (rsp_busy_res),
   .rsp_done_res (rsp_done_res),
   .rsp_rejected (rsp_rejected)
);

### tb/tb_i2c_register_write_master.sv
// Self-checking testbench for i2c_register_write_master: sends tick and write
// request transactions and checks the pin levels and flags of every response.
// Depends on i2crw_pkg and the i2c_register_write_master design.
module tb_i2c_register_write_master;
   import i2crw_pkg::*;

   localparam logic ModeTick = 1'b0;
   localparam logic ModeWrite = 1'b1;
   localparam int LimitCycles = 300000;
   localparam int LongHoldCycles = 200;
   localparam int DrainCycles = 8;
   localparam logic [TickWidth-1:0] LongestHold = 16'hFFFF;

   // Bus sequence of the local prediction; mirrors the start, data bits and
   // stop portions of one write frame.
   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'd0,
      SEQ_START = 3'd1,
      SEQ_BITS  = 3'd2,
      SEQ_STOP  = 3'd3
   } bus_seq_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_mode = 1'b0;
   logic [6:0] req_device_address = '0;
   logic [7:0] req_register_index = '0;
   logic [7:0] req_write_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_scl_out;
   logic rsp_sda_out;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic rsp_rejected;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TickWidth-1:0] csr_phase_ticks = '0;

   // Predicted state of the bus sequencer and its hold time setting.
   bus_seq_type seq_now = SEQ_IDLE;
   logic [PosWidth-1:0] bit_idx = '0;
   logic [1:0] level_idx = '0;
   logic [TickWidth-1:0] hold_count = '0;
   logic [TickWidth-1:0] hold_limit = PhaseTicksReset;
   frame_type frame_left = '0;
   logic scl_line = 1'b1;
   logic sda_line = 1'b1;

   // Levels and flags still owed by the block, oldest first.
   i2crw_result_type expected_bus_levels[$];
   i2crw_result_type rsp_want;

   int mismatch_count = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic rx_holding = 1'b0;
   event hold_off_go;

   i2c_register_write_master u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_device_address (req_device_address),
      .req_register_index (req_register_index),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scl_out        (rsp_scl_out),
      .rsp_sda_out        (rsp_sda_out),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_rejected       (rsp_rejected),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_phase_ticks    (csr_phase_ticks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction of the bus levels
   // ------------------------------------------------------------------

   function automatic logic frame_active();
      return seq_now != SEQ_IDLE;
   endfunction

   // Sets SCL and SDA for the level that the sequencer has just entered. The
   // first level of each data bit shifts the next frame bit onto SDA.
   function automatic void set_line_levels();
      case (seq_now)
         SEQ_START: begin
            scl_line = (level_idx == 2'd0);
            sda_line = 1'b0;
         end
         SEQ_BITS: begin
            if (level_idx == 2'd0) begin
               sda_line = frame_left[FrameBits-1];
               frame_left = frame_left << 1;
               scl_line = 1'b0;
            end else begin
               scl_line = (level_idx == 2'd1);
            end
         end
         SEQ_STOP: begin
            scl_line = 1'b1;
            sda_line = (level_idx != 2'd0);
         end
         default: begin
            scl_line = 1'b1;
            sda_line = 1'b1;
         end
      endcase
   endfunction

   // Moves to the next pin level; returns 1 when the stop condition completes.
   function automatic logic next_line_level();
      logic finished;
      finished = 1'b0;
      case (seq_now)
         SEQ_START: begin
            if (level_idx == 2'd0) begin
               level_idx = 2'd1;
            end else begin
               seq_now = SEQ_BITS;
               bit_idx = '0;
               level_idx = 2'd0;
            end
         end
         SEQ_BITS: begin
            if (level_idx < 2'd2) begin
               level_idx = level_idx + 2'd1;
            end else if (bit_idx >= LastBitPos) begin
               seq_now = SEQ_STOP;
               level_idx = 2'd0;
            end else begin
               bit_idx = bit_idx + PosWidth'(1);
               level_idx = 2'd0;
            end
         end
         SEQ_STOP: begin
            if (level_idx == 2'd0) begin
               level_idx = 2'd1;
            end else begin
               seq_now = SEQ_IDLE;
               level_idx = 2'd0;
               bit_idx = '0;
               finished = 1'b1;
            end
         end
         default: begin
            seq_now = SEQ_IDLE;
         end
      endcase
      set_line_levels();
      return finished;
   endfunction

   // Works out the response to one accepted request transaction. A write
   // request while idle loads the frame and enters the first start level at
   // once; while busy it is refused and time does not advance. A tick counts
   // toward the hold time, and a hold time of zero behaves as one.
   function automatic i2crw_result_type predict_bus_levels(input logic mode,
                                                           input logic [6:0] addr,
                                                           input logic [7:0] reg_byte,
                                                           input logic [7:0] data_byte);
      i2crw_result_type levels;
      logic was_busy;
      logic [TickWidth-1:0] limit;
      levels = '0;
      was_busy = frame_active();
      if (mode == ModeWrite) begin
         if (was_busy) begin
            levels.rejected = 1'b1;
         end else begin
            frame_left = {addr, 1'b0, 1'b1, reg_byte, 1'b1, data_byte, 1'b1};
            seq_now = SEQ_START;
            bit_idx = '0;
            level_idx = 2'd0;
            hold_count = '0;
            set_line_levels();
         end
      end else if (was_busy) begin
         limit = (hold_limit == '0) ? TickWidth'(1) : hold_limit;
         hold_count = hold_count + TickWidth'(1);
         if (hold_count >= limit) begin
            hold_count = '0;
            levels.done = next_line_level();
         end
      end
      levels.scl = scl_line;
      levels.sda = sda_line;
      levels.busy = frame_active();
      return levels;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offers one request transaction, after a random gap, and records the
   // response it must produce once the block takes it. Valid stays high when
   // no gap follows, so back-to-back transactions never drop it.
   task automatic send_item(input logic mode, input logic [6:0] addr,
                            input logic [7:0] reg_byte, input logic [7:0] data_byte);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_device_address <= addr;
      req_register_index <= reg_byte;
      req_write_value <= data_byte;
      do @(posedge clock); while (req_stall);
      expected_bus_levels.push_back(predict_bus_levels(mode, addr, reg_byte, data_byte));
      items_sent++;
   endtask

   // Address and data fields of a tick are ignored, so they carry noise.
   task automatic send_tick();
      send_item(ModeTick, 7'($urandom_range(127)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   task automatic send_random_write();
      send_item(ModeWrite, 7'($urandom_range(127)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
   endtask

   task automatic finish_frame();
      while (frame_active()) begin
         send_tick();
      end
   endtask

   // The sender pauses here until every outstanding response has come back.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_bus_levels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The hold time changes only with no transaction in flight. A frame may
   // still be in progress; the new setting then applies from the next tick.
   task automatic write_phase_ticks(input logic [TickWidth-1:0] ticks);
      wait_for_responses();
      csr_phase_ticks <= ticks;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hold_limit = ticks;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset value of the hold time: an idle tick keeps both lines released, a
   // write starts a frame, a second write is refused, and the first level
   // change comes on the twentieth tick.
   task automatic test_reset_value();
      send_tick();
      send_item(ModeWrite, 7'h7F, 8'h00, 8'hFF);
      send_item(ModeWrite, 7'h00, 8'hFF, 8'h00);
      repeat (2 * int'(PhaseTicksReset) + 1) begin
         send_tick();
      end
   endtask

   // A hold time of zero acts as one. The frame left over from the previous
   // test runs out under the new setting, and a write is sent on the very
   // transaction after the stop condition ends.
   task automatic test_zero_hold();
      write_phase_ticks('0);
      finish_frame();
      send_item(ModeWrite, 7'h00, 8'hFF, 8'h00);
      finish_frame();
      send_tick();
   endtask

   // Alternating bit patterns at a hold time of one, with a refused write in
   // the middle of the data bits.
   task automatic test_single_tick_hold();
      write_phase_ticks(TickWidth'(1));
      send_item(ModeWrite, 7'h2A, 8'h55, 8'hAA);
      repeat (30) begin
         send_tick();
      end
      send_item(ModeWrite, 7'h55, 8'hAA, 8'h55);
      finish_frame();
      send_item(ModeWrite, 7'h55, 8'hAA, 8'h55);
      finish_frame();
   endtask

   // Mostly complete frames with random content. Between frames a few idle
   // ticks are mixed in, and now and then a write arrives while busy.
   task automatic test_random_traffic(input logic [TickWidth-1:0] ticks, input int idle_pct,
                                      input int stall_pct, input int count);
      int stop_at;
      write_phase_ticks(ticks);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if (frame_active()) begin
            if ($urandom_range(24) == 0) begin
               send_random_write();
            end else begin
               send_tick();
            end
         end else if ($urandom_range(3) == 0) begin
            send_tick();
         end else begin
            send_random_write();
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so both internal registers fill and the request side stalls.
   task automatic test_backpressure();
      write_phase_ticks(TickWidth'(1));
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_random_write();
      -> hold_off_go;
      repeat (60) begin
         if ($urandom_range(9) == 0) begin
            send_random_write();
         end else begin
            send_tick();
         end
      end
      wait_for_responses();
   endtask

   // Longest hold time: the frame barely moves, and a refused write still
   // leaves the hold count where it was.
   task automatic test_longest_hold();
      write_phase_ticks(LongestHold);
      sender_idle_pct = 30;
      receiver_stall_pct = 30;
      send_random_write();
      repeat (300) begin
         send_tick();
      end
      send_random_write();
      repeat (20) begin
         send_tick();
      end
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic want_bit,
                                       input logic got_bit);
      if (got_bit !== want_bit) begin
         $error("%s: expected %0b, actual %0b", name, want_bit, got_bit);
         mismatch_count++;
      end
   endfunction

   // Compares every accepted response with the oldest expectation, then
   // decides the stall for the next cycle.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (expected_bus_levels.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatch_count++;
         end else begin
            rsp_want = expected_bus_levels.pop_front();
            check_field("scl_out", rsp_want.scl, rsp_scl_out);
            check_field("sda_out", rsp_want.sda, rsp_sda_out);
            check_field("busy_res", rsp_want.busy, rsp_busy_res);
            check_field("done_res", rsp_want.done, rsp_done_res);
            check_field("rejected", rsp_want.rejected, rsp_rejected);
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_holding) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Long receiver hold-off, counted here in clock cycles.
   always begin
      @(hold_off_go);
      rx_holding <= 1'b1;
      repeat (LongHoldCycles) @(posedge clock);
      rx_holding <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LimitCycles) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_value();
      test_zero_hold();
      test_single_tick_hold();
      test_random_traffic('0, 0, 0, 300);
      test_random_traffic(TickWidth'(2), 60, 0, 300);
      test_random_traffic(TickWidth'(1), 0, 60, 300);
      test_random_traffic(TickWidth'(3), 30, 30, 300);
      test_backpressure();
      test_longest_hold();
      wait_for_responses();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
design/i2crw_pkg.sv
design/i2crw_engine.sv
design/i2c_register_write_master.sv
design/i2crw_checker.sv
tb/tb_i2c_register_write_master.sv
